// ----- rtl/core/dvl_pkg.sv -----
`default_nettype none

package dvl_pkg;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_REM_FRONT = 3'd2,
        OP_REM_BACK  = 3'd3,
        OP_LIST      = 3'd4
    } dvl_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } dvl_status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } dvl_state_t;

    // controller to datapath
    typedef struct packed {
        logic        ins_front;
        logic        ins_back;
        logic        rem_front;
        logic        rem_back;
        logic        list_load;
        logic        list_read;
        logic        emit;
        dvl_status_t emit_status;
    } dvl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic list_final;
    } dvl_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/double_ended_value_list_core.sv -----
// channel   | ports                             | handshake
// ----------+-----------------------------------+-------------------------------
// command   | start, busy, command, value       | taken when start && !busy
// result    | result_valid, status, element,    | one-cycle strobe, no backpressure
//           | last                              |
//
// insert and remove are applied on acceptance; the result shows the cycle after acceptance
// a list holds busy while the single read port of the ring store walks front to
// back, one element per cycle, each result showing the cycle after its read
// unused command codes are absorbed with no result
// reset (rst_n low, asynchronous) empties the list; store contents are not cleared
// results cannot be stalled by the receiver
`default_nettype none

module double_ended_value_list_core #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [dvl_pkg::CMD_W-1:0]           command,
    input  wire logic signed [dvl_pkg::DATA_W-1:0]   value,
    output logic                                     result_valid,
    output logic [dvl_pkg::STATUS_W-1:0]             status,
    output logic signed [dvl_pkg::DATA_W-1:0]        element,
    output logic                                     last
);

    dvl_pkg::dvl_cmd_t  cmd;
    dvl_pkg::dvl_stat_t stat;

    dvl_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    dvl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .value        (value),
        .stat         (stat),
        .result_valid (result_valid),
        .status       (status),
        .element      (element),
        .last         (last)
    );

endmodule

`default_nettype wire

// ----- rtl/core/dvl_ctrl.sv -----
`default_nettype none

module dvl_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [dvl_pkg::CMD_W-1:0]   command,
    input  wire dvl_pkg::dvl_stat_t          stat,
    output dvl_pkg::dvl_cmd_t                cmd,
    output logic                             busy
);

    dvl_pkg::dvl_state_t state_reg;
    dvl_pkg::dvl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dvl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.emit_status = dvl_pkg::ST_OK;
        busy            = 1'b0;
        unique case (state_reg)
            dvl_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (command)
                        dvl_pkg::OP_INS_FRONT:
                        begin
                            cmd.emit = 1'b1;
                            if (stat.full)
                            begin
                                cmd.emit_status = dvl_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.ins_front = 1'b1;
                            end
                        end
                        dvl_pkg::OP_INS_BACK:
                        begin
                            cmd.emit = 1'b1;
                            if (stat.full)
                            begin
                                cmd.emit_status = dvl_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.ins_back = 1'b1;
                            end
                        end
                        dvl_pkg::OP_REM_FRONT:
                        begin
                            cmd.emit = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.emit_status = dvl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.rem_front = 1'b1;
                            end
                        end
                        dvl_pkg::OP_REM_BACK:
                        begin
                            cmd.emit = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.emit_status = dvl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.rem_back = 1'b1;
                            end
                        end
                        dvl_pkg::OP_LIST:
                        begin
                            if (stat.empty)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = dvl_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.list_load = 1'b1;
                                state_next    = dvl_pkg::S_LIST;
                            end
                        end
                        // unused codes do nothing
                        default:
                        begin
                        end
                    endcase
                end
            end
            dvl_pkg::S_LIST:
            begin
                busy          = 1'b1;
                cmd.list_read = 1'b1;
                if (stat.list_final)
                begin
                    state_next = dvl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dvl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/dvl_datapath.sv -----
`default_nettype none

module dvl_datapath #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire dvl_pkg::dvl_cmd_t                   cmd,
    input  wire logic signed [dvl_pkg::DATA_W-1:0]   value,
    output dvl_pkg::dvl_stat_t                       stat,
    output logic                                     result_valid,
    output logic [dvl_pkg::STATUS_W-1:0]             status,
    output logic signed [dvl_pkg::DATA_W-1:0]        element,
    output logic                                     last
);

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned SUM_W = CNT_W + 1;

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);
    localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(CAPACITY);

    logic signed [dvl_pkg::DATA_W-1:0] mem [CAPACITY];

    logic [IDX_W-1:0] front_reg,     front_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic [IDX_W-1:0] rd_ptr_reg,    rd_ptr_next;
    logic [CNT_W-1:0] remain_reg,    remain_next;
    logic             valid_reg,     valid_next;
    logic [dvl_pkg::STATUS_W-1:0] status_reg, status_next;
    logic             last_reg,      last_next;
    logic             list_out_reg,  list_out_next;
    logic signed [dvl_pkg::DATA_W-1:0] rd_data_reg;

    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic [IDX_W-1:0] rd_ptr_inc;
    logic [SUM_W-1:0] back_sum;
    logic [IDX_W-1:0] back_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    assign front_dec  = (front_reg == '0) ? IDX_MAX : front_reg - 1'b1;
    assign front_inc  = (front_reg == IDX_MAX) ? '0 : front_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == IDX_MAX) ? '0 : rd_ptr_reg + 1'b1;

    // ring wrap of front + count, sum stays below twice the capacity
    assign back_sum  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign back_addr = (back_sum >= SUM_CAP) ? IDX_W'(back_sum - SUM_CAP) : IDX_W'(back_sum);

    assign wr_en   = cmd.ins_front | cmd.ins_back;
    assign wr_addr = cmd.ins_front ? front_dec : back_addr;

    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg >= CNT_CAP);
    assign stat.list_final = (remain_reg == CNT_W'(1));

    always_comb
    begin
        front_next    = front_reg;
        count_next    = count_reg;
        rd_ptr_next   = rd_ptr_reg;
        remain_next   = remain_reg;
        valid_next    = 1'b0;
        status_next   = dvl_pkg::ST_OK;
        last_next     = 1'b0;
        list_out_next = 1'b0;
        if (cmd.ins_front)
        begin
            front_next = front_dec;
            count_next = count_reg + 1'b1;
        end
        if (cmd.ins_back)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.rem_front)
        begin
            front_next = front_inc;
            count_next = count_reg - 1'b1;
        end
        if (cmd.rem_back)
        begin
            count_next = count_reg - 1'b1;
        end
        if (cmd.list_load)
        begin
            rd_ptr_next = front_reg;
            remain_next = count_reg;
        end
        if (cmd.emit)
        begin
            valid_next  = 1'b1;
            status_next = cmd.emit_status;
            last_next   = 1'b1;
        end
        if (cmd.list_read)
        begin
            rd_ptr_next   = rd_ptr_inc;
            remain_next   = remain_reg - 1'b1;
            valid_next    = 1'b1;
            last_next     = stat.list_final;
            list_out_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            count_reg    <= '0;
            rd_ptr_reg   <= '0;
            remain_reg   <= '0;
            valid_reg    <= 1'b0;
            list_out_reg <= 1'b0;
        end
        else
        begin
            front_reg    <= front_next;
            count_reg    <= count_next;
            rd_ptr_reg   <= rd_ptr_next;
            remain_reg   <= remain_next;
            valid_reg    <= valid_next;
            list_out_reg <= list_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (cmd.list_read)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign last         = last_reg;
    assign element      = list_out_reg ? rd_data_reg : '0;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_CAP)
        else $error("element count above capacity");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg <= IDX_MAX)
        else $error("front index out of ring");

    a_read_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.list_read |-> (remain_reg != '0))
        else $error("list read with nothing left");

    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit && cmd.list_read))
        else $error("two results in one cycle");

    a_list_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.list_read |=> (result_valid && status == dvl_pkg::ST_OK))
        else $error("list read without ok result");

endmodule

`default_nettype wire

// ----- sim/tb_double_ended_value_list_core.sv -----
`default_nettype none

module tb_double_ended_value_list_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dvl_pkg::*;

    localparam int DEPTH = 16;
    localparam int RANDOM_ITEMS = 470;
    localparam logic [CMD_W-1:0] FIRST_UNUSED_CMD = 3'd5;
    localparam logic [CMD_W-1:0] LAST_UNUSED_CMD  = 3'd7;

    typedef struct {
        dvl_status_t        status;
        logic signed [31:0] element;
        logic               last;
    } deque_result_t;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic signed [31:0] val;
        bit                 typed;
        dvl_status_t        typed_status;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [CMD_W-1:0]           command;
    logic signed [DATA_W-1:0]   value;
    logic                       result_valid;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   element;
    logic                       last;

    // shadow copy of the ring store
    logic signed [31:0] shadow_store [DEPTH];
    int                 shadow_front;
    int                 shadow_count;

    deque_result_t      step_results [$];
    deque_result_t      awaited_results [$];

    int                 idle_pct;
    int                 mismatch_count;
    int                 counted_items;
    int                 op_seen [8];
    int                 full_rejects;
    int                 empty_hits;
    int                 listed_elements;
    int                 longest_list;

    double_ended_value_list_core #(
        .CAPACITY(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .value(value),
        .result_valid(result_valid),
        .status(status),
        .element(element),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic step_shadow_deque(input logic [CMD_W-1:0] cmd, input logic signed [31:0] val);
        int k;
        step_results.delete();
        case (cmd)
            OP_INS_FRONT, OP_INS_BACK:
            begin
                if (shadow_count == DEPTH)
                begin
                    step_results.push_back(deque_result_t'{ST_FULL, 32'sd0, 1'b1});
                    full_rejects++;
                end
                else
                begin
                    if (cmd == OP_INS_FRONT)
                    begin
                        shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                        shadow_store[shadow_front] = val;
                    end
                    else
                    begin
                        shadow_store[(shadow_front + shadow_count) % DEPTH] = val;
                    end
                    shadow_count++;
                    step_results.push_back(deque_result_t'{ST_OK, 32'sd0, 1'b1});
                end
            end
            OP_REM_FRONT, OP_REM_BACK:
            begin
                if (shadow_count == 0)
                begin
                    step_results.push_back(deque_result_t'{ST_EMPTY, 32'sd0, 1'b1});
                    empty_hits++;
                end
                else
                begin
                    if (cmd == OP_REM_FRONT)
                        shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                    step_results.push_back(deque_result_t'{ST_OK, 32'sd0, 1'b1});
                end
            end
            OP_LIST:
            begin
                if (shadow_count == 0)
                begin
                    step_results.push_back(deque_result_t'{ST_EMPTY, 32'sd0, 1'b1});
                    empty_hits++;
                end
                else
                begin
                    for (k = 0; k < shadow_count; k++)
                        step_results.push_back(deque_result_t'{ST_OK,
                            shadow_store[(shadow_front + k) % DEPTH],
                            logic'(k == shadow_count - 1)});
                    listed_elements += shadow_count;
                    if (shadow_count > longest_list)
                        longest_list = shadow_count;
                end
            end
            default: ;
        endcase
    endtask

    // drive one transaction, wait for it to be taken, then queue what it should produce
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic signed [31:0] val,
                                input bit typed, input dvl_status_t typed_status);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start   <= 1'b1;
        command <= cmd;
        value   <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        step_shadow_deque(cmd, val);
        if (typed)
        begin
            step_results.delete();
            step_results.push_back(deque_result_t'{typed_status, 32'sd0, 1'b1});
        end
        foreach (step_results[i])
            awaited_results.push_back(step_results[i]);
        op_seen[cmd]++;
        if (cmd <= OP_LIST)
            counted_items++;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(15))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && result_valid)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result: status=%0d element=%0d last=%0b",
                       status, element, last);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, status);
                    mismatch_count++;
                end
                if (element !== want.element)
                begin
                    $error("element mismatch: expected %0d, actual %0d", want.element, element);
                    mismatch_count++;
                end
                if (last !== want.last)
                begin
                    $error("last mismatch: expected %0b, actual %0b", want.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t        directed [];
        logic [CMD_W-1:0] op;
        int               pick;
        int               n;

        rst_n          = 1'b0;
        start          = 1'b0;
        command        = OP_INS_FRONT;
        value          = '0;
        shadow_front   = 0;
        shadow_count   = 0;
        mismatch_count = 0;
        counted_items  = 0;
        full_rejects   = 0;
        empty_hits     = 0;
        listed_elements = 0;
        longest_list   = 0;
        idle_pct       = 7;
        foreach (op_seen[i])
            op_seen[i] = 0;

        directed = '{
            '{OP_REM_FRONT,         32'sd0,           1'b1, ST_EMPTY},
            '{OP_REM_BACK,          32'sd0,           1'b1, ST_EMPTY},
            '{OP_LIST,              32'sd0,           1'b1, ST_EMPTY},
            '{OP_INS_BACK,          32'sh7FFF_FFFF,   1'b1, ST_OK},
            // front insert wraps the front index below zero
            '{OP_INS_FRONT,         32'sh8000_0000,   1'b1, ST_OK},
            '{OP_LIST,              -32'sd1,          1'b0, ST_OK},
            '{FIRST_UNUSED_CMD,     32'sh1234_5678,   1'b0, ST_OK},
            '{FIRST_UNUSED_CMD + 1, -32'sd1,          1'b0, ST_OK},
            '{LAST_UNUSED_CMD,      32'sh8000_0000,   1'b0, ST_OK},
            '{OP_INS_BACK,          32'sd0,           1'b1, ST_OK},
            '{OP_INS_FRONT,         -32'sd1,          1'b1, ST_OK},
            '{OP_LIST,              32'sd0,           1'b0, ST_OK},
            '{OP_REM_FRONT,         32'sh7FFF_FFFF,   1'b1, ST_OK},
            '{OP_REM_BACK,          -32'sd1,          1'b1, ST_OK},
            '{OP_LIST,              32'sh5555_AAAA,   1'b0, ST_OK},
            '{OP_REM_BACK,          32'sd0,           1'b1, ST_OK},
            '{OP_REM_FRONT,         32'sd0,           1'b1, ST_OK},
            '{OP_REM_FRONT,         32'sd0,           1'b1, ST_EMPTY},
            '{OP_LIST,              32'sd0,           1'b1, ST_EMPTY}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_command(directed[i].cmd, directed[i].val, directed[i].typed,
                         directed[i].typed_status);

        counted_items = 0;
        while (counted_items < RANDOM_ITEMS)
        begin
            if (counted_items < RANDOM_ITEMS / 3)
                idle_pct = 7;
            else if (counted_items < 2 * RANDOM_ITEMS / 3)
                idle_pct = 59;
            else
                idle_pct = 0;

            pick = $urandom_range(99);
            if (pick < 18)
            begin
                // fill up and push past full
                n = DEPTH - shadow_count + $urandom_range(2, 1);
                repeat (n)
                begin
                    op = $urandom_range(1) ? OP_INS_BACK : OP_INS_FRONT;
                    send_command(op, pick_value(), 1'b0, ST_OK);
                end
                if ($urandom_range(1))
                    send_command(OP_LIST, pick_value(), 1'b0, ST_OK);
            end
            else if (pick < 32)
            begin
                // drain and keep removing past empty
                n = shadow_count + $urandom_range(2, 1);
                repeat (n)
                begin
                    op = $urandom_range(1) ? OP_REM_BACK : OP_REM_FRONT;
                    send_command(op, pick_value(), 1'b0, ST_OK);
                end
                send_command(OP_LIST, pick_value(), 1'b0, ST_OK);
            end
            else if (pick < 50)
            begin
                send_command(OP_LIST, pick_value(), 1'b0, ST_OK);
            end
            else if (pick < 96)
            begin
                op = $urandom_range(OP_REM_BACK, OP_INS_FRONT);
                send_command(op, pick_value(), 1'b0, ST_OK);
            end
            else
            begin
                op = $urandom_range(LAST_UNUSED_CMD, FIRST_UNUSED_CMD);
                send_command(op, pick_value(), 1'b0, ST_OK);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("commands: ins_front=%0d ins_back=%0d rem_front=%0d rem_back=%0d list=%0d unused=%0d",
                 op_seen[OP_INS_FRONT], op_seen[OP_INS_BACK], op_seen[OP_REM_FRONT],
                 op_seen[OP_REM_BACK], op_seen[OP_LIST],
                 op_seen[5] + op_seen[6] + op_seen[7]);
        $display("full rejects=%0d empty hits=%0d listed elements=%0d longest list=%0d",
                 full_rejects, empty_hits, listed_elements, longest_list);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
